### sv/assert_macros.svh
// Assertion helpers shared by the RTL; clk and rst_n must be in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/rtbc_pkg.sv
`timescale 1ns / 1ps
package rtbc_pkg;

  localparam int unsigned OVH_START   = 1910;
  localparam int unsigned OVH_SET     = 1320;
  localparam int unsigned OVH_END     = 960;
  localparam int unsigned OVH_MSRC    = 660;
  localparam int unsigned OVH_TCC     = 590;
  localparam int unsigned OVH_DSS     = 690;
  localparam int unsigned OVH_PRE     = 660;
  localparam int unsigned OVH_FINAL   = 550;
  localparam int unsigned MIN_BUDGET  = 20000;
  // reciprocal of 125 scaled by 2**36, for divides by 1000 after a shift by 3
  localparam logic [29:0] RECIP_125   = 30'd549755814;

  typedef logic [19:0] macro_t;
  typedef macro_t macro_tbl_t [128];

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_LOW     = 2'd1,
    ST_SMALL   = 2'd2,
    ST_FIN_OFF = 2'd3
  } status_t;

  typedef struct packed {
    logic tcc;
    logic dss;
    logic msrc;
    logic pre;
    logic fin;
  } flags_t;

  typedef struct packed {
    logic [31:0] cur;
    status_t     status;
    logic [31:0] num;
    macro_t      div;
    logic [15:0] pre_add;
  } qent_t;

  typedef struct packed {
    logic [20:0] rem;
    logic [31:0] n;
    logic [31:0] q;
    macro_t      d;
    logic [31:0] cur;
    status_t     status;
    logic [15:0] pre_add;
  } div_t;

  function automatic macro_tbl_t build_macro_tbl();
    macro_tbl_t      t;
    longint unsigned p;
    longint unsigned v;
    for (int i = 0; i < 128; i++) begin
      p = (2 * (i + 1)) % 256;
      v = (64'd3813120 * p + 500) / 1000;
      t[i] = v[19:0];
    end
    return t;
  endfunction

  // macro period in ns, indexed by the low 7 bits of a period code
  localparam macro_tbl_t MACRO_TBL = build_macro_tbl();

  function automatic logic [15:0] decode_timeout(logic [15:0] code);
    logic [15:0] v;
    v = (code[15:8] < 8'd16) ? (16'(code[7:0]) << code[11:8]) : 16'd0;
    return v + 16'd1;
  endfunction

  // (prod + 500) / 1000, prod already wrapped to 32 bits
  function automatic logic [22:0] us_from_prod(logic [31:0] prod);
    logic [31:0] s;
    logic [58:0] p;
    s = prod + 32'd500;
    p = 59'(s[31:3]) * 59'(RECIP_125);
    return p[58:36];
  endfunction

  function automatic logic [15:0] encode_timeout(logic [15:0] m);
    logic [15:0] ls;
    logic [3:0]  ms;
    logic [15:0] sh;
    ls = m - 16'd1;
    ms = 4'd0;
    for (int k = 8; k < 16; k++) begin
      if (ls[k]) ms = 4'(k - 7);
    end
    sh = ls >> ms;
    return (m == 16'd0) ? 16'd0 : {4'd0, ms, sh[7:0]};
  endfunction

  // four restoring-division steps
  function automatic div_t div4(div_t s);
    div_t r;
    r = s;
    for (int i = 0; i < 4; i++) begin
      r.rem = {r.rem[19:0], r.n[31]};
      r.n   = {r.n[30:0], 1'b0};
      if (r.rem >= 21'(r.d)) begin
        r.rem = r.rem - 21'(r.d);
        r.q   = {r.q[30:0], 1'b1};
      end else begin
        r.q   = {r.q[30:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

### sv/rtbc_if.sv
`timescale 1ns / 1ps
interface rtbc_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  step_enables;
  logic [7:0]  msrc_timeout_code;
  logic [15:0] pre_range_timeout_code;
  logic [15:0] final_range_timeout_code;
  logic [7:0]  pre_range_period_code;
  logic [7:0]  final_range_period_code;
  logic [31:0] requested_budget_us;

  modport source (output valid, step_enables, msrc_timeout_code, pre_range_timeout_code,
                  final_range_timeout_code, pre_range_period_code, final_range_period_code,
                  requested_budget_us, input ready);
  modport sink (input valid, step_enables, msrc_timeout_code, pre_range_timeout_code,
                final_range_timeout_code, pre_range_period_code, final_range_period_code,
                requested_budget_us, output ready);
endinterface

interface rtbc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] current_budget_us;
  logic [15:0] new_final_timeout_code;
  logic [1:0]  set_status;

  modport source (output valid, current_budget_us, new_final_timeout_code, set_status,
                  input ready);
  modport sink (input valid, current_budget_us, new_final_timeout_code, set_status,
                output ready);
endinterface

### sv/rtbc_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rtbc_front (
  input  logic            clk,
  input  logic            rst_n,
  rtbc_in_if.sink         in_ch,
  input  logic            q_full,
  output logic            push,
  output rtbc_pkg::qent_t push_data
);

  logic [4:0] v_r;
  logic       en;

  // stage 1: decode
  rtbc_pkg::flags_t fl1_r;
  rtbc_pkg::macro_t pre_mac1_r, fin_mac1_r;
  logic [8:0]       msrc_m1_r;
  logic [15:0]      pre_m1_r, fin_m1_r;
  logic [31:0]      bud1_r;
  // stage 2: products
  rtbc_pkg::flags_t fl2_r;
  rtbc_pkg::macro_t fin_mac2_r;
  logic [15:0]      pre_m2_r;
  logic [31:0]      bud2_r, msrc_p2_r, pre_p2_r, fin_p2_r;
  // stage 3: microseconds
  rtbc_pkg::flags_t fl3_r;
  rtbc_pkg::macro_t fin_mac3_r;
  logic [15:0]      pre_m3_r;
  logic [31:0]      bud3_r;
  logic [22:0]      msrc_us3_r, pre_us3_r, fin_us3_r;
  // stage 4: sums and status
  rtbc_pkg::macro_t fin_mac4_r;
  logic [15:0]      pre_add4_r;
  logic [31:0]      cur4_r, diff4_r;
  rtbc_pkg::status_t st4_r;
  // stage 5: numerator
  rtbc_pkg::qent_t  q5_r;

  rtbc_pkg::flags_t fl_in;
  logic [15:0]      pre_m_in, fin_m_in;
  logic [31:0]      steps, cur_nxt, used;
  rtbc_pkg::status_t st_nxt;

  assign en          = !(v_r[4] && q_full);
  assign in_ch.ready = en;
  assign push        = v_r[4] && !q_full;
  assign push_data   = q5_r;

  always_comb begin
    fl_in.tcc  = in_ch.step_enables[4];
    fl_in.dss  = in_ch.step_enables[3];
    fl_in.msrc = in_ch.step_enables[2];
    fl_in.pre  = in_ch.step_enables[6];
    fl_in.fin  = in_ch.step_enables[7];
    pre_m_in   = rtbc_pkg::decode_timeout(in_ch.pre_range_timeout_code);
    fin_m_in   = rtbc_pkg::decode_timeout(in_ch.final_range_timeout_code);
    if (fl_in.pre) fin_m_in = fin_m_in - pre_m_in;
  end

  always_comb begin
    steps = 32'd0;
    if (fl3_r.tcc) steps = steps + 32'(msrc_us3_r) + 32'(rtbc_pkg::OVH_TCC);
    if (fl3_r.dss) begin
      steps = steps + ((32'(msrc_us3_r) + 32'(rtbc_pkg::OVH_DSS)) << 1);
    end else if (fl3_r.msrc) begin
      steps = steps + 32'(msrc_us3_r) + 32'(rtbc_pkg::OVH_MSRC);
    end
    if (fl3_r.pre) steps = steps + 32'(pre_us3_r) + 32'(rtbc_pkg::OVH_PRE);
    cur_nxt = 32'(rtbc_pkg::OVH_START + rtbc_pkg::OVH_END) + steps;
    if (fl3_r.fin) cur_nxt = cur_nxt + 32'(fin_us3_r) + 32'(rtbc_pkg::OVH_FINAL);
    used = 32'(rtbc_pkg::OVH_SET + rtbc_pkg::OVH_END + rtbc_pkg::OVH_FINAL) + steps;
    if (bud3_r < 32'(rtbc_pkg::MIN_BUDGET)) st_nxt = rtbc_pkg::ST_LOW;
    else if (!fl3_r.fin)                    st_nxt = rtbc_pkg::ST_FIN_OFF;
    else if (used > bud3_r)                 st_nxt = rtbc_pkg::ST_SMALL;
    else                                    st_nxt = rtbc_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fl1_r      <= fl_in;
      pre_mac1_r <= rtbc_pkg::MACRO_TBL[in_ch.pre_range_period_code[6:0]];
      fin_mac1_r <= rtbc_pkg::MACRO_TBL[in_ch.final_range_period_code[6:0]];
      msrc_m1_r  <= 9'(in_ch.msrc_timeout_code) + 9'd1;
      pre_m1_r   <= pre_m_in;
      fin_m1_r   <= fin_m_in;
      bud1_r     <= in_ch.requested_budget_us;

      fl2_r      <= fl1_r;
      fin_mac2_r <= fin_mac1_r;
      pre_m2_r   <= pre_m1_r;
      bud2_r     <= bud1_r;
      msrc_p2_r  <= 32'(36'(msrc_m1_r) * 36'(pre_mac1_r));
      pre_p2_r   <= 32'(36'(pre_m1_r) * 36'(pre_mac1_r));
      fin_p2_r   <= 32'(36'(fin_m1_r) * 36'(fin_mac1_r));

      fl3_r      <= fl2_r;
      fin_mac3_r <= fin_mac2_r;
      pre_m3_r   <= pre_m2_r;
      bud3_r     <= bud2_r;
      msrc_us3_r <= rtbc_pkg::us_from_prod(msrc_p2_r);
      pre_us3_r  <= rtbc_pkg::us_from_prod(pre_p2_r);
      fin_us3_r  <= rtbc_pkg::us_from_prod(fin_p2_r);

      fin_mac4_r <= fin_mac3_r;
      pre_add4_r <= fl3_r.pre ? pre_m3_r : 16'd0;
      cur4_r     <= cur_nxt;
      diff4_r    <= bud3_r - used;
      st4_r      <= st_nxt;

      q5_r.cur     <= cur4_r;
      q5_r.status  <= st4_r;
      q5_r.num     <= 32'(diff4_r * 32'd1000) + 32'(fin_mac4_r >> 1);
      q5_r.div     <= fin_mac4_r;
      q5_r.pre_add <= pre_add4_r;
    end
  end

  `ASSERT_NEXT(a_front_hold, v_r[4] && q_full, v_r[4], "front dropped a stalled word")

endmodule

### sv/rtbc_fifo.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rtbc_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rtbc_pkg::qent_t push_data,
  output logic            full,
  input  logic            pop,
  output rtbc_pkg::qent_t pop_data,
  output logic            empty
);

  rtbc_pkg::qent_t mem_r [2];
  logic            wptr_r, rptr_r;
  logic [1:0]      cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= !wptr_r;
      if (pop)  rptr_r <= !rptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_data;
  end

  `ASSERT_IMP(a_no_overflow, push, !full, "push into full queue")
  `ASSERT_IMP(a_no_underflow, pop, !empty, "pop from empty queue")
  `ASSERT_IMP(a_cnt_range, 1'b1, cnt_r <= 2'd2, "queue count out of range")

endmodule

### sv/rtbc_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rtbc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  rtbc_pkg::qent_t head,
  input  logic            empty,
  output logic            pop,
  rtbc_out_if.source      out_ch
);

  rtbc_pkg::div_t    st_r [8];
  logic [7:0]        vb_r;
  logic              out_valid_r;
  logic [31:0]       cur_r;
  logic [15:0]       code_r;
  rtbc_pkg::status_t status_r;

  rtbc_pkg::div_t init;
  logic [31:0]    m;
  logic           en;

  assign en  = !out_valid_r || out_ch.ready;
  assign pop = en && !empty;

  always_comb begin
    init.rem     = '0;
    init.n       = head.num;
    init.q       = '0;
    init.d       = head.div;
    init.cur     = head.cur;
    init.status  = head.status;
    init.pre_add = head.pre_add;
    m = st_r[7].q + 32'(st_r[7].pre_add);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vb_r        <= {vb_r[6:0], !empty};
      out_valid_r <= vb_r[7];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= rtbc_pkg::div4(init);
      for (int k = 1; k < 8; k++) st_r[k] <= rtbc_pkg::div4(st_r[k-1]);
      cur_r    <= st_r[7].cur;
      status_r <= st_r[7].status;
      code_r   <= (st_r[7].status == rtbc_pkg::ST_OK) ?
                  rtbc_pkg::encode_timeout(m[15:0]) : 16'd0;
    end
  end

  assign out_ch.valid                  = out_valid_r;
  assign out_ch.current_budget_us      = cur_r;
  assign out_ch.new_final_timeout_code = code_r;
  assign out_ch.set_status             = status_r;

  `ASSERT_IMP(a_code_on_fail, out_valid_r && status_r != rtbc_pkg::ST_OK, code_r == 16'd0,
              "timeout code set on failed status")

endmodule

### sv/ranging_timing_budget_calc.sv
`timescale 1ns / 1ps
// Channel  | Dir | Handshake   | Word
// in_ch    | in  | valid/ready | sequence byte, timeout and period codes, budget
// out_ch   | out | valid/ready | current budget, final timeout code, status
//
// One word per cycle sustained while out_ch is ready; the front pipeline
// and the 8-stage divider (4 quotient bits per stage) each take one word
// every cycle unless held by a stall.
// Reset (rst_n low, synchronous) empties all stages and the 2-entry queue.
// A stalled output holds the divider; with words streaming, the queue takes
// one more word and in_ch.ready drops in the cycle after the output stalls.
module ranging_timing_budget_calc (
  input  logic       clk,
  input  logic       rst_n,
  rtbc_in_if.sink    in_ch,
  rtbc_out_if.source out_ch
);

  rtbc_pkg::qent_t push_data, head;
  logic            push, pop, full, empty;

  rtbc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_full    (full),
    .push      (push),
    .push_data (push_data)
  );

  rtbc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (head),
    .empty     (empty)
  );

  rtbc_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
